>>> hw/rtl/plob_pkg.sv
// Shared types and field widths for the price-level order book.
`default_nettype none
package plob_pkg;
  localparam int unsigned PriceW = 10;
  localparam int unsigned InQtyW = 24;
  localparam int unsigned OutQtyW = 32;
  localparam int unsigned SpreadW = 11;
  localparam int unsigned ReqW = 2 + PriceW + InQtyW;

  localparam logic OpAdd = 1'b0;
  localparam logic OpRemove = 1'b1;

  typedef struct packed {
    logic              op;
    logic              side;
    logic [PriceW-1:0] price;
    logic [InQtyW-1:0] quantity;
  } req_t;
endpackage
`default_nettype wire

>>> hw/rtl/plob_front.sv
// Input stage and two-entry queue feeding the book update engine.
`default_nettype none
module plob_front
  import plob_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  output logic in_ready_o,
  input  req_t in_req_i,
  output logic q_valid_o,
  input  wire  q_ready_i,
  output req_t q_req_o
);
  req_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_req_o    = mem_q[rd_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = q_valid_o && q_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_req_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/plob_side.sv
// One side of the book: level totals in RAM, two-level presence bitmap.
`default_nettype none
module plob_side
  import plob_pkg::*;
#(
  parameter int unsigned PRICE_LEVELS = 1024,
  parameter int unsigned LEVEL_QUANTITY_BITS = 32,
  parameter bit          FIND_HIGH = 1'b1
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  // stage controls from the engine
  input  wire                                  rd_en_i,
  input  wire  [$clog2(PRICE_LEVELS)-1:0]      idx_i,
  input  wire                                  upd_en_i,
  input  wire                                  op_i,
  input  wire  [InQtyW-1:0]                    qty_i,
  input  wire                                  srch_en_i,
  input  wire                                  best_rd_i,
  output logic                                 valid_o,
  output logic [$clog2(PRICE_LEVELS)-1:0]      best_o,
  output logic [LEVEL_QUANTITY_BITS-1:0]       best_qty_o
);
  localparam int unsigned AW = $clog2(PRICE_LEVELS);
  localparam int unsigned GW = (AW + 1) / 2;
  localparam int unsigned RW = AW - GW;
  localparam int unsigned Groups = (PRICE_LEVELS + (1 << RW) - 1) >> RW;
  localparam int unsigned QW = LEVEL_QUANTITY_BITS;
  localparam logic [QW-1:0] QMax = '1;

  logic [QW-1:0]        ram [PRICE_LEVELS];
  logic [(1<<RW)-1:0]   row_q [Groups];
  logic [Groups-1:0]    sum_q;
  logic [QW-1:0]        rdata_q, wdata, cur;
  logic [AW-1:0]        best_q;
  logic                 pres_cur, pres_new, valid_q;
  logic [GW-1:0]        grp, grp_q;
  logic                 grp_ok;
  logic [RW-1:0]        bit_sel;
  logic                 row_ok;
  logic [QW:0]          sum_add;
  logic [QW-1:0]        qext;
  logic [AW-1:0]        ram_addr;
  logic                 fine_q;

  assign pres_cur = row_q[idx_i[AW-1:RW]][idx_i[RW-1:0]];
  // an absent level counts as a zero total, so RAM contents there do not matter
  assign cur = pres_cur ? rdata_q : '0;
  assign qext = QW'(qty_i);
  assign sum_add = {1'b0, cur} + {1'b0, qext};

  // apply the update to the level read in the previous cycle
  always_comb begin
    wdata = cur;
    pres_new = pres_cur;
    if (op_i == OpAdd) begin
      wdata = sum_add[QW] ? QMax : sum_add[QW-1:0];
      if (InQtyW > QW && (qty_i >> QW) != '0) wdata = QMax;
      pres_new = 1'b1;
    end else if (pres_cur) begin
      if (qext >= cur || (InQtyW > QW && (qty_i >> QW) != '0)) begin
        wdata = '0;
        pres_new = 1'b0;
      end else begin
        wdata = cur - qext;
      end
    end
  end

  // coarse search over group summary bits
  always_comb begin
    grp = '0;
    grp_ok = 1'b0;
    for (int unsigned g = 0; g < Groups; g++) begin
      if (sum_q[g] && (FIND_HIGH || !grp_ok)) begin
        grp = GW'(g);
        grp_ok = 1'b1;
      end
    end
  end

  always_comb begin
    bit_sel = '0;
    row_ok = 1'b0;
    for (int unsigned b = 0; b < (1 << RW); b++) begin
      if (row_q[grp_q][b] && (FIND_HIGH || !row_ok)) begin
        bit_sel = RW'(b);
        row_ok = 1'b1;
      end
    end
  end

  assign ram_addr = best_rd_i ? best_q : idx_i;

  always_ff @(posedge clk_i) begin
    if (rd_en_i || best_rd_i) rdata_q <= ram[ram_addr];
    if (upd_en_i) ram[idx_i] <= wdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned g = 0; g < Groups; g++) row_q[g] <= '0;
      sum_q <= '0;
      grp_q <= '0;
      valid_q <= 1'b0;
      best_q <= '0;
      fine_q <= 1'b0;
    end else begin
      if (upd_en_i) begin
        row_q[idx_i[AW-1:RW]][idx_i[RW-1:0]] <= pres_new;
      end
      fine_q <= srch_en_i;
      if (srch_en_i) begin
        grp_q <= grp;
        valid_q <= grp_ok;
      end
      if (fine_q) best_q <= valid_q ? {grp_q, bit_sel} : '0;
      for (int unsigned g = 0; g < Groups; g++) sum_q[g] <= |row_q[g];
    end
  end

  assign valid_o = valid_q;
  assign best_o = best_q;
  assign best_qty_o = valid_q ? rdata_q : '0;
endmodule
`default_nettype wire

>>> hw/rtl/plob_engine.sv
// Back end: sequences read, update, search and best-level read per item.
`default_nettype none
module plob_engine
  import plob_pkg::*;
#(
  parameter int unsigned PRICE_LEVELS = 1024,
  parameter int unsigned LEVEL_QUANTITY_BITS = 32
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         q_valid_i,
  output logic        q_ready_o,
  input  req_t        q_req_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [OutQtyW*2+PriceW*2+SpreadW+2:0] out_data_o
);
  localparam int unsigned AW = $clog2(PRICE_LEVELS);
  localparam int unsigned QW = LEVEL_QUANTITY_BITS;
  localparam logic [2:0] StIdle = 3'd0, StRead = 3'd1, StUpd = 3'd2, StSum = 3'd3,
                         StSrch = 3'd4, StFine = 3'd5, StBest = 3'd6, StOut = 3'd7;

  logic [2:0]  st_q, st_d;
  req_t        req_q;
  logic        in_range;
  logic        bv, av;
  logic [AW-1:0] bb, ba;
  logic [QW-1:0] bq, aq;
  logic [AW-1:0] idx;
  logic        out_valid_q;
  logic [OutQtyW*2+PriceW*2+SpreadW+2:0] out_q, res;
  logic signed [AW+1:0] sp;
  logic signed [SpreadW-1:0] sps;
  logic [OutQtyW-1:0] bq32, aq32;

  assign idx = AW'(req_q.price);
  assign in_range = (32'(req_q.price) < PRICE_LEVELS);
  assign q_ready_o = (st_q == StIdle);

  plob_side #(.PRICE_LEVELS(PRICE_LEVELS), .LEVEL_QUANTITY_BITS(QW), .FIND_HIGH(1'b1))
  u_bid (
    .clk_i, .rst_ni,
    .rd_en_i(st_q == StRead), .idx_i(idx),
    .upd_en_i(st_q == StUpd && in_range && req_q.side),
    .op_i(req_q.op), .qty_i(req_q.quantity),
    .srch_en_i(st_q == StSrch), .best_rd_i(st_q == StBest),
    .valid_o(bv), .best_o(bb), .best_qty_o(bq)
  );

  plob_side #(.PRICE_LEVELS(PRICE_LEVELS), .LEVEL_QUANTITY_BITS(QW), .FIND_HIGH(1'b0))
  u_ask (
    .clk_i, .rst_ni,
    .rd_en_i(st_q == StRead), .idx_i(idx),
    .upd_en_i(st_q == StUpd && in_range && !req_q.side),
    .op_i(req_q.op), .qty_i(req_q.quantity),
    .srch_en_i(st_q == StSrch), .best_rd_i(st_q == StBest),
    .valid_o(av), .best_o(ba), .best_qty_o(aq)
  );

  // best level settles at the end of StFine; its total is read in StBest
  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle: if (q_valid_i) st_d = StRead;
      StRead: st_d = StUpd;
      StUpd:  st_d = StSum;
      StSum:  st_d = StSrch;
      StSrch: st_d = StFine;
      StFine: st_d = StBest;
      StBest: st_d = StOut;
      StOut:  if (!out_valid_q) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_comb begin
    sp = $signed({2'b0, ba}) - $signed({2'b0, bb});
    if (sp > 1023) sps = 11'sd1023;
    else if (sp < -1023) sps = -11'sd1023;
    else sps = SpreadW'(sp);
    bq32 = OutQtyW'(bq);
    aq32 = OutQtyW'(aq);
    res = {(bv && av) ? sps : '0, bv && av,
           aq32, av ? PriceW'(ba) : '0, av,
           bq32, bv ? PriceW'(bb) : '0, bv};
  end

  always_ff @(posedge clk_i) begin
    if (q_valid_i && q_ready_o) req_q <= q_req_i;
    if (st_q == StOut && !out_valid_q) out_q <= res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == StOut && !out_valid_q) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;
endmodule
`default_nettype wire

>>> hw/rtl/price_level_order_book_core.sv
// Top level of the price-level order book.
// For each item the engine steps through queue pop, level RAM read, update write,
// group summary refresh, coarse search, fine search, a RAM read of each
// side's best total, and result capture, and it takes no new item until the
// last one is captured. The per-side level RAM has one port, which sets that
// sequence. A two-entry queue buffers input transfers; the result sits in an
// output register so the next item proceeds while it waits, and the engine
// holds at result capture only while the previous result is still unaccepted.
`default_nettype none
module price_level_order_book_core
  import plob_pkg::*;
#(
  parameter int unsigned PRICE_LEVELS = 1024,
  parameter int unsigned LEVEL_QUANTITY_BITS = 32
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // op, side, price[9:0], quantity[23:0], zero pad
  input  wire  [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // bid_valid, best_bid_price, best_bid_quantity, ask_valid, best_ask_price,
  // best_ask_quantity, spread_valid, spread[10:0], zero pad
  output logic [103:0] m_axis_tdata
);
  req_t in_req, q_req;
  logic q_valid, q_ready;
  logic [OutQtyW*2+PriceW*2+SpreadW+2:0] res;

  assign in_req.op = s_axis_tdata[0];
  assign in_req.side = s_axis_tdata[1];
  assign in_req.price = s_axis_tdata[11:2];
  assign in_req.quantity = s_axis_tdata[35:12];

  plob_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_req_i(in_req),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_req_o(q_req)
  );

  plob_engine #(.PRICE_LEVELS(PRICE_LEVELS), .LEVEL_QUANTITY_BITS(LEVEL_QUANTITY_BITS))
  u_engine (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_req_i(q_req),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_data_o(res)
  );

  assign m_axis_tdata = {6'b0, res};
endmodule
`default_nettype wire

>>> dv/price_level_order_book_core_tb.sv
// Testbench for the price-level order book: random stream traffic checked against a level-book predictor.
`timescale 1ns / 1ps
module price_level_order_book_core_tb;
  import plob_pkg::*;

  localparam int unsigned Levels = 1024;
  localparam logic SideAsk = 1'b0;
  localparam logic SideBid = 1'b1;
  localparam logic [23:0] QtyMax = 24'hFFFFFF;

  typedef struct packed {
    logic               spread_valid;
    logic signed [10:0] spread;
    logic               ask_valid;
    logic [9:0]         ask_price;
    logic [31:0]        ask_qty;
    logic               bid_valid;
    logic [9:0]         bid_price;
    logic [31:0]        bid_qty;
  } top_of_book_t;

  class book_scoreboard;
    bit [31:0]    bid_total[Levels];
    bit [31:0]    ask_total[Levels];
    bit           bid_live[Levels];
    bit           ask_live[Levels];
    top_of_book_t pending[$];
    int           errors;

    function new();
      errors = 0;
      foreach (bid_total[i]) begin
        bid_total[i] = '0;
        ask_total[i] = '0;
        bid_live[i] = 1'b0;
        ask_live[i] = 1'b0;
      end
    endfunction

    function void apply_level(ref bit [31:0] total[Levels], ref bit live[Levels],
                              input req_t r);
      bit [32:0] sum;
      sum = {1'b0, total[r.price]} + r.quantity;
      if (r.op == OpAdd) begin
        total[r.price] = sum[32] ? 32'hFFFFFFFF : sum[31:0];
        live[r.price] = 1'b1;
      end else if (live[r.price]) begin
        if (r.quantity >= total[r.price]) begin
          total[r.price] = '0;
          live[r.price] = 1'b0;
        end else begin
          total[r.price] = total[r.price] - r.quantity;
        end
      end
    endfunction

    // update the book for one accepted transfer and queue the expected top of book
    function void note_update(req_t r);
      top_of_book_t e;
      int diff;
      if (r.side == SideBid) apply_level(bid_total, bid_live, r);
      else apply_level(ask_total, ask_live, r);
      e = '0;
      for (int i = 0; i < Levels; i++) begin
        if (bid_live[i]) begin
          e.bid_valid = 1'b1;
          e.bid_price = i[9:0];
          e.bid_qty = bid_total[i];
        end
        if (!e.ask_valid && ask_live[i]) begin
          e.ask_valid = 1'b1;
          e.ask_price = i[9:0];
          e.ask_qty = ask_total[i];
        end
      end
      if (e.bid_valid && e.ask_valid) begin
        diff = int'(e.ask_price) - int'(e.bid_price);
        if (diff > 1023) diff = 1023;
        if (diff < -1023) diff = -1023;
        e.spread_valid = 1'b1;
        e.spread = diff[10:0];
      end
      pending.push_back(e);
    endfunction

    function void check_result(logic [103:0] d);
      top_of_book_t e;
      if (pending.size() == 0) begin
        $error("unexpected result transfer: %h", d);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[0] !== e.bid_valid) begin
        $error("bid_valid exp %0d act %0d", e.bid_valid, d[0]); errors++;
      end
      if (d[10:1] !== e.bid_price) begin
        $error("best_bid_price exp %0d act %0d", e.bid_price, d[10:1]); errors++;
      end
      if (d[42:11] !== e.bid_qty) begin
        $error("best_bid_quantity exp %0d act %0d", e.bid_qty, d[42:11]); errors++;
      end
      if (d[43] !== e.ask_valid) begin
        $error("ask_valid exp %0d act %0d", e.ask_valid, d[43]); errors++;
      end
      if (d[53:44] !== e.ask_price) begin
        $error("best_ask_price exp %0d act %0d", e.ask_price, d[53:44]); errors++;
      end
      if (d[85:54] !== e.ask_qty) begin
        $error("best_ask_quantity exp %0d act %0d", e.ask_qty, d[85:54]); errors++;
      end
      if (d[86] !== e.spread_valid) begin
        $error("spread_valid exp %0d act %0d", e.spread_valid, d[86]); errors++;
      end
      if (d[97:87] !== e.spread) begin
        $error("spread exp %0d act %0d", e.spread, $signed(d[97:87])); errors++;
      end
    endfunction
  endclass

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [39:0]  s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [103:0] m_axis_tdata;

  book_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;

  price_level_order_book_core u_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  // op in bit 0, then side, price and quantity
  function automatic req_t unpack_req(logic [39:0] d);
    req_t r;
    r.op = d[0];
    r.side = d[1];
    r.price = d[11:2];
    r.quantity = d[35:12];
    return r;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("status: fail");
    $finish;
  end

  // monitor both buses at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) sb.note_update(unpack_req(s_axis_tdata));
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_order(logic op, logic side, logic [9:0] price, logic [23:0] qty);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0, qty, price, side, op};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_random(int center);
    logic [9:0] price;
    logic [23:0] qty;
    int pick;
    pick = $urandom_range(99);
    // mostly a narrow window so removes hit live levels
    if (pick < 80) price = 10'(center + $urandom_range(24) - 12);
    else price = 10'($urandom_range(1023));
    pick = $urandom_range(99);
    if (pick < 40) qty = 24'($urandom_range(200));
    else if (pick < 50) qty = QtyMax;
    else if (pick < 55) qty = '0;
    else qty = 24'($urandom);
    send_order($urandom_range(99) < 45, $urandom_range(1), price, qty);
  endtask

  initial begin
    int center;
    sb = new();
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_order(OpRemove, SideBid, 10'd5, 24'd7);        // remove on empty level
    send_order(OpAdd, SideAsk, 10'd0, 24'd0);           // zero add makes level live
    send_order(OpAdd, SideBid, 10'd1023, QtyMax);       // crossed to the extreme
    send_order(OpRemove, SideAsk, 10'd0, 24'd0);        // remove to zero clears
    send_order(OpAdd, SideBid, 10'd0, 24'd5);
    send_order(OpRemove, SideBid, 10'd1023, QtyMax);
    send_order(OpAdd, SideAsk, 10'd1023, 24'd1);        // widest positive spread
    send_order(OpRemove, SideBid, 10'd0, 24'd3);
    send_order(OpRemove, SideBid, 10'd0, 24'd9);        // remove below zero
    send_order(OpAdd, SideAsk, 10'd512, 24'h800000);
    send_order(OpAdd, SideBid, 10'd511, 24'h7FFFFF);
    send_order(OpAdd, SideBid, 10'd512, 24'h123456);    // touching book
    send_order(OpRemove, SideAsk, 10'd700, 24'd1);
    send_order(OpRemove, SideAsk, 10'd512, QtyMax);
    send_order(OpRemove, SideAsk, 10'd1023, 24'd1);
    send_order(OpRemove, SideBid, 10'd512, QtyMax);
    send_order(OpRemove, SideBid, 10'd511, QtyMax);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 62; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 62; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      center = $urandom_range(1000, 20);
      for (int n = 0; n < 140; n++) begin
        if (n % 35 == 0) center = $urandom_range(1000, 20);
        send_random(center);
      end
    end

    // saturate the top bid level, then nibble at it
    send_idle_pct = 0;
    recv_stall_pct = 20;
    repeat (258) send_order(OpAdd, SideBid, 10'd1023, QtyMax);
    send_order(OpRemove, SideBid, 10'd1023, 24'd1);
    send_order(OpRemove, SideBid, 10'd1023, 24'd0);
    send_order(OpAdd, SideBid, 10'd1023, 24'd1);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
